FILE: hw/rtl/assert_macros.svh
// assertion macros used by the rtl decoder core
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/ookpg_pkg.sv
// shared types and constants for the ook pulse-gap sensor decoder
// no dependencies
package ookpg_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned GAP_CFG_W = 16;
  localparam int unsigned ID_W = 4;
  localparam int unsigned CHAN_W = 3;
  localparam int unsigned TEMP_RAW_W = 12;
  localparam int unsigned TEMP_W = 16;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_MIN    = 3'd0,
    REG_FILTER_MAX    = 3'd1,
    REG_MEDIUM        = 3'd2,
    REG_START         = 3'd3,
    REG_STOP          = 3'd4,
    REG_REPEAT_WINDOW = 3'd5
  } cfg_idx_t;

  // command codes
  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // register reset values
  localparam logic [GAP_CFG_W-1:0] FILTER_MIN_RST = 16'd950;
  localparam logic [GAP_CFG_W-1:0] FILTER_MAX_RST = 16'd9500;
  localparam logic [GAP_CFG_W-1:0] MEDIUM_RST     = 16'd3000;
  localparam logic [GAP_CFG_W-1:0] START_RST      = 16'd9000;
  localparam logic [GAP_CFG_W-1:0] STOP_RST       = 16'd2000;
  localparam logic [TIME_W-1:0]    REPEAT_RST     = 32'd3000000;

  typedef struct packed {
    logic                     frame_ready;
    logic [ID_W-1:0]          sensor_id;
    logic [CHAN_W-1:0]        sensor_channel;
    logic signed [TEMP_W-1:0] temperature_x10;
  } result_t;

endpackage

FILE: hw/rtl/ook_pulse_gap_sensor_decoder_core.sv
// top level of the ook pulse-gap sensor decoder: gap classification, frame
// assembly, repeat check and field decode. depends on ookpg_pkg, assert_macros.svh
//
// usage:
//   input channel (in_valid / in_stall) carries command and edge_time_us.
//   command CMD_EDGE reports a falling edge with its microsecond timestamp;
//   command CMD_READ reports the decoded frame and clears the pending one.
//   every input transaction yields exactly one result transaction on the
//   output channel (out_valid / out_stall): frame_ready, sensor_id,
//   sensor_channel, temperature_x10.
//   config channel (cfg_valid / cfg_ready) writes the six timing registers;
//   cfg_ready is always high. write only while the block is idle.
//   results go to the output register, or the skid entry under out_stall.
//   throughput: one item per cycle while in_stall is low; gap subtract,
//   window compares and the repeat compare form one combinational pass
//   into the registers. an output register plus one skid entry part the
//   channels: input keeps flowing while one result waits; in_stall is
//   high while the skid entry is full.
//   rst (synchronous) restores register defaults, clears decoder state and the valid flags.
module ook_pulse_gap_sensor_decoder_core #(
  parameter int unsigned FRAME_BITS = 36
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    command,
  input  logic [ookpg_pkg::TIME_W-1:0]            edge_time_us,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic                                    frame_ready,
  output logic [ookpg_pkg::ID_W-1:0]              sensor_id,
  output logic [ookpg_pkg::CHAN_W-1:0]            sensor_channel,
  output logic signed [ookpg_pkg::TEMP_W-1:0]     temperature_x10,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [ookpg_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ookpg_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import ookpg_pkg::*;

  localparam int unsigned BC_W = $clog2(FRAME_BITS + 1);

  // configuration registers
  logic [GAP_CFG_W-1:0] filter_min_us, filter_max_us, medium_us, start_us, stop_us;
  logic [TIME_W-1:0]    repeat_window_us;

  // decoder state
  logic [TIME_W-1:0]     last_edge_time, last_edge_time_next;
  logic                  in_frame, in_frame_next;
  logic [BC_W-1:0]       bit_count, bit_count_next;
  logic [FRAME_BITS-1:0] received_bits, received_bits_next;
  logic [FRAME_BITS-1:0] previous_frame, previous_frame_next;
  logic [TIME_W-1:0]     previous_frame_time, previous_frame_time_next;
  logic                  pending, pending_next;

  // result registers
  result_t result, result_next;
  result_t main_res, skid_res;
  logic    skid_valid;

  logic              accept;
  logic [TIME_W-1:0] gap;
  logic              in_window;
  logic              data_bit;
  logic              frame_match;
  logic              repeat_ok;
  logic              frame_full;

  logic              edge_acc, read_acc, frame_clear;

  logic [TEMP_RAW_W-1:0]    temp_raw;
  logic signed [TEMP_W-1:0] temp_ext;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign accept    = in_valid && !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_min_us    <= FILTER_MIN_RST;
      filter_max_us    <= FILTER_MAX_RST;
      medium_us        <= MEDIUM_RST;
      start_us         <= START_RST;
      stop_us          <= STOP_RST;
      repeat_window_us <= REPEAT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FILTER_MIN:    filter_min_us    <= cfg_data[GAP_CFG_W-1:0];
        REG_FILTER_MAX:    filter_max_us    <= cfg_data[GAP_CFG_W-1:0];
        REG_MEDIUM:        medium_us        <= cfg_data[GAP_CFG_W-1:0];
        REG_START:         start_us         <= cfg_data[GAP_CFG_W-1:0];
        REG_STOP:          stop_us          <= cfg_data[GAP_CFG_W-1:0];
        REG_REPEAT_WINDOW: repeat_window_us <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // gap with 32-bit wrap and its classification
  assign gap        = edge_time_us - last_edge_time;
  assign in_window  = (gap > TIME_W'(filter_min_us)) && (gap < TIME_W'(filter_max_us));
  assign data_bit   = !(gap < TIME_W'(medium_us));
  assign frame_match = (received_bits == previous_frame);
  assign repeat_ok  = (edge_time_us - previous_frame_time) < repeat_window_us;
  assign frame_full = (bit_count == BC_W'(FRAME_BITS));

  // field decode, frame bit 0 sits at the msb
  assign temp_raw = received_bits[FRAME_BITS-17 -: TEMP_RAW_W];
  assign temp_ext = TEMP_W'(signed'(temp_raw));

  always_comb begin
    last_edge_time_next      = last_edge_time;
    in_frame_next            = in_frame;
    bit_count_next           = bit_count;
    received_bits_next       = received_bits;
    previous_frame_next      = previous_frame;
    previous_frame_time_next = previous_frame_time;
    pending_next             = pending;
    result_next              = '0;

    if (accept) begin
      if (command == CMD_EDGE) begin
        last_edge_time_next = edge_time_us;
        if (in_window && !pending) begin
          if (gap > TIME_W'(start_us)) begin
            in_frame_next      = 1'b1;
            bit_count_next     = '0;
            received_bits_next = '0;
          end else if (in_frame) begin
            if (gap < TIME_W'(stop_us)) begin
              // a short stop gap before the frame is full leaves it open
              if (frame_full) begin
                in_frame_next            = 1'b0;
                previous_frame_time_next = edge_time_us;
                if (frame_match) begin
                  pending_next = repeat_ok;
                end else begin
                  previous_frame_next = received_bits;
                end
              end
            end else if (!frame_full) begin
              received_bits_next = {received_bits[FRAME_BITS-2:0], data_bit};
              bit_count_next     = bit_count + BC_W'(1);
            end
          end
        end
        result_next.frame_ready = pending_next;
      end else begin
        result_next.frame_ready     = pending;
        result_next.sensor_id       = received_bits[FRAME_BITS-1 -: ID_W];
        result_next.sensor_channel  = {1'b0, received_bits[FRAME_BITS-15 -: 2]} + CHAN_W'(1);
        result_next.temperature_x10 = (temp_ext <<< 3) + (temp_ext <<< 1);
        pending_next   = 1'b0;
        in_frame_next  = 1'b0;
        bit_count_next = '0;
      end
    end
  end

  assign result = result_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time      <= '0;
      in_frame            <= 1'b0;
      bit_count           <= '0;
      received_bits       <= '0;
      previous_frame      <= '0;
      previous_frame_time <= '0;
      pending             <= 1'b0;
    end else begin
      last_edge_time      <= last_edge_time_next;
      in_frame            <= in_frame_next;
      bit_count           <= bit_count_next;
      received_bits       <= received_bits_next;
      previous_frame      <= previous_frame_next;
      previous_frame_time <= previous_frame_time_next;
      pending             <= pending_next;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_stall) begin
      if (accept) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_stall) begin
      if (accept) begin
        skid_res <= result;
      end
    end else if (skid_valid) begin
      main_res <= skid_res;
    end else if (accept) begin
      main_res <= result;
    end
  end

  assign frame_ready     = main_res.frame_ready;
  assign sensor_id       = main_res.sensor_id;
  assign sensor_channel  = main_res.sensor_channel;
  assign temperature_x10 = main_res.temperature_x10;

  assign edge_acc    = accept && (command == CMD_EDGE);
  assign read_acc    = accept && (command == CMD_READ);
  assign frame_clear = !pending && !in_frame && (bit_count == '0);

  `include "assert_macros.svh"

  `ASSERT_IMPL(a_skid_behind_main, clk, rst, skid_valid, out_valid, "skid entry without output")
  `ASSERT_IMPL(a_bit_count_bound, clk, rst, 1'b1, bit_count <= BC_W'(FRAME_BITS), "bit overflow")
  `ASSERT_NEXT(a_pending_holds_on_edge, clk, rst, edge_acc && pending, pending, "pending lost")
  `ASSERT_NEXT(a_read_clears, clk, rst, read_acc, frame_clear, "read left frame state behind")

endmodule
